/* rtl/assert_macros.svh */
// Assertion macros shared by the key recovery RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slkr_pkg.sv */
// Shared constants, types and the inverse S-box lookup for key recovery.
// Depends on nothing; used by slkr_cell, slkr_scan and the top level.
`default_nettype none

package slkr_pkg;

  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned NumCand       = 256;
  localparam int unsigned IdxWidth      = 8;
  localparam int unsigned PairWidth     = 16;
  localparam int unsigned NibWidth      = 4;
  localparam int unsigned SboxWidth     = 64;

  // Per-cell controls driven from the top level
  typedef struct packed {
    logic count_en;  // a pair is accepted this cycle
    logic shift_en;  // counts move one cell towards the scanner
  } cell_ctrl_t;

  // Inverse S-box: image of v sits at bits 4v+3..4v
  function automatic logic [NibWidth-1:0] inv_nib(input logic [SboxWidth-1:0] tbl,
                                                  input logic [NibWidth-1:0] v);
    inv_nib = tbl[{v, 2'b00} +: NibWidth];
  endfunction

endpackage

`default_nettype wire

/* rtl/slkr_cell.sv */
// One candidate cell: a saturating counter that also acts as a shift stage.
// Depends on slkr_pkg for the control struct.
`default_nettype none

module slkr_cell #(
  parameter int unsigned CountWidth = slkr_pkg::CountWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire slkr_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic                   hit_i,
  input  wire logic [CountWidth-1:0]  shift_i,
  output logic      [CountWidth-1:0]  count_o
);

  localparam logic [CountWidth-1:0] CntMax = {CountWidth{1'b1}};

  logic [CountWidth-1:0] cnt_q, cnt_d;

  // shifting in from the neighbour wins; otherwise count hits, saturating
  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.shift_en) begin
      cnt_d = shift_i;
    end else if (ctrl_i.count_en && hit_i && (cnt_q != CntMax)) begin
      cnt_d = cnt_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

`default_nettype wire

/* rtl/slkr_scan.sv */
// Scanner at the head of the cell chain: walks the counts out one a cycle,
// the last one held for a free output, and keeps the largest bias. Depends on slkr_pkg for widths.
`default_nettype none

module slkr_scan #(
  parameter int unsigned CountWidth = slkr_pkg::CountWidthDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic                                slot_free_i,
  input  wire logic [CountWidth-1:0]               count_i,
  input  wire logic [slkr_pkg::PairWidth-1:0]      half_i,
  output logic                                     draining_o,
  output logic                                     shift_en_o,
  output logic                                     done_o,
  output logic      [slkr_pkg::IdxWidth-1:0]       best_idx_o,
  output logic      [slkr_pkg::PairWidth-1:0]      best_bias_o
);

  localparam int unsigned DiffWidth =
    (CountWidth > slkr_pkg::PairWidth) ? CountWidth : slkr_pkg::PairWidth;
  localparam logic [slkr_pkg::IdxWidth-1:0] LastIdx = {slkr_pkg::IdxWidth{1'b1}};
  localparam logic [DiffWidth-1:0] BiasMax = DiffWidth'({slkr_pkg::PairWidth{1'b1}});

  typedef enum logic {ScIdle, ScDrain} state_e;

  state_e                       state_q;
  logic [slkr_pkg::IdxWidth-1:0] idx_q;
  logic [DiffWidth-1:0]         best_q;
  logic [slkr_pkg::IdxWidth-1:0] best_idx_q;

  logic [DiffWidth-1:0]         cnt_w, half_w, diff;
  logic                         take;
  logic [DiffWidth-1:0]         best_d;
  logic [slkr_pkg::IdxWidth-1:0] best_idx_d;

  // bias of the count now at the chain head
  always_comb begin
    cnt_w  = DiffWidth'(count_i);
    half_w = DiffWidth'(half_i);
    diff   = (cnt_w >= half_w) ? (cnt_w - half_w) : (half_w - cnt_w);
    // strict compare keeps the lowest index on a tie
    take       = (idx_q == '0) || (diff > best_q);
    best_d     = take ? diff : best_q;
    best_idx_d = take ? idx_q : best_idx_q;
  end

  // last step waits until the output register is free
  assign draining_o  = (state_q == ScDrain);
  assign shift_en_o  = draining_o && ((idx_q != LastIdx) || slot_free_i);
  assign done_o      = shift_en_o && (idx_q == LastIdx);
  assign best_idx_o  = best_idx_d;
  assign best_bias_o = (best_d > BiasMax) ? slkr_pkg::PairWidth'(BiasMax)
                                          : best_d[slkr_pkg::PairWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ScIdle;
      idx_q      <= '0;
      best_q     <= '0;
      best_idx_q <= '0;
    end else begin
      case (state_q)
        ScIdle: begin
          idx_q <= '0;
          if (start_i) begin
            state_q <= ScDrain;
          end
        end
        ScDrain: begin
          if (shift_en_o) begin
            best_q     <= best_d;
            best_idx_q <= best_idx_d;
            idx_q      <= idx_q + slkr_pkg::IdxWidth'(1);
            if (idx_q == LastIdx) begin
              state_q <= ScIdle;
            end
          end
        end
        default: begin
          state_q <= ScIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/spn_linear_key_recovery_unit.sv */
// Top level of the 16-bit SPN linear key recovery unit: config register,
// 256-cell counter chain, scanner and output register. Depends on slkr_pkg,
// slkr_cell, slkr_scan and assert_macros.svh.
//
//   channel   direction  payload (low bit up)                          handshake
//   s_axis    in         tdata: plaintext, ciphertext; tlast: last_pair tvalid/tready
//   m_axis    out        tdata: key_high, key_low, best_bias, pairs_used tvalid/tready
//   cfg       in         cfg_wdata_i: inverse_sbox_table               cfg_we_i
//
// One pair per cycle outside a scan: all 256 cell counters update in the cycle
// of acceptance. A last pair starts a scan in which the counts shift down the
// cell chain into the scanner, one a cycle; tready is low during it. The scan
// also clears the chain. Its final step holds while an earlier result is still
// waiting on m_axis. After reset all counters and the pair total are zero.
`default_nettype none

`include "assert_macros.svh"

module spn_linear_key_recovery_unit #(
  parameter int unsigned COUNT_WIDTH = slkr_pkg::CountWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // plaintext[15:0], ciphertext[31:16]
  input  wire logic        s_axis_tlast,   // last_pair
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // key_high_nibble[3:0], key_low_nibble[7:4], best_bias[23:8], pairs_used[39:24]
  output logic      [39:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i
);

  localparam int unsigned NC = slkr_pkg::NumCand;
  localparam int unsigned NW = slkr_pkg::NibWidth;
  localparam int unsigned PW = slkr_pkg::PairWidth;
  localparam logic [PW-1:0] PairMax = {PW{1'b1}};

  logic [slkr_pkg::SboxWidth-1:0] sbox_q;
  logic [PW-1:0]                  pair_total_q;
  logic                           out_valid_q;
  logic [39:0]                    out_data_q;

  logic                 accept;
  logic [PW-1:0]        ptext, ctext;
  logic                 xpar;
  logic [15:0]          par_hi, par_lo;
  slkr_pkg::cell_ctrl_t cell_ctrl;
  logic [COUNT_WIDTH-1:0] counts [NC];

  logic                        draining, shift_en, done;
  logic [slkr_pkg::IdxWidth-1:0] best_idx;
  logic [PW-1:0]               best_bias;

  assign ptext  = s_axis_tdata[15:0];
  assign ctext  = s_axis_tdata[31:16];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !draining;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbox_q <= '0;
    end else if (cfg_we_i) begin
      sbox_q <= cfg_wdata_i;
    end
  end

  // per-nibble parities of u bits 2 and 0 for every key nibble guess
  assign xpar = ptext[11] ^ ptext[9] ^ ptext[8];
  always_comb begin
    logic [NW-1:0] uh, ul;
    for (int v = 0; v < 16; v++) begin
      uh = slkr_pkg::inv_nib(sbox_q, ctext[11:8] ^ NW'(v));
      ul = slkr_pkg::inv_nib(sbox_q, ctext[3:0] ^ NW'(v));
      par_hi[v] = uh[2] ^ uh[0];
      par_lo[v] = ul[2] ^ ul[0];
    end
  end

  assign cell_ctrl.count_en = accept;
  assign cell_ctrl.shift_en = shift_en;

  // candidate chain; cell i holds key high nibble i[7:4], low nibble i[3:0]
  for (genvar i = 0; i < NC; i++) begin : g_cell
    localparam logic [7:0] Idx = 8'(i);
    logic [COUNT_WIDTH-1:0] shift_in;
    if (i == NC - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_link
      assign shift_in = counts[i+1];
    end
    slkr_cell #(
      .CountWidth (COUNT_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .hit_i   (~(xpar ^ par_hi[Idx[7:4]] ^ par_lo[Idx[3:0]])),
      .shift_i (shift_in),
      .count_o (counts[i])
    );
  end

  slkr_scan #(
    .CountWidth (COUNT_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && s_axis_tlast),
    .slot_free_i (!out_valid_q || m_axis_tready),
    .count_i     (counts[0]),
    .half_i      (pair_total_q >> 1),
    .draining_o  (draining),
    .shift_en_o  (shift_en),
    .done_o      (done),
    .best_idx_o  (best_idx),
    .best_bias_o (best_bias)
  );

  // pair total, saturating, cleared once the result is formed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_total_q <= '0;
    end else if (done) begin
      pair_total_q <= '0;
    end else if (accept && (pair_total_q != PairMax)) begin
      pair_total_q <= pair_total_q + PW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= {pair_total_q, best_bias, best_idx[3:0], best_idx[7:4]};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `ASSERT_NEXT(a_last_starts_scan, clk_i, rst_ni, accept && s_axis_tlast, draining,
               "last pair did not start the scan")
  `ASSERT_NEXT(a_done_clears_total, clk_i, rst_ni, done, pair_total_q == '0,
               "pair total not cleared after result")
  `ASSERT_IMPL(a_result_from_scan, clk_i, rst_ni, $rose(m_axis_tvalid), $past(done),
               "result appeared without a finished scan")
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, done, !out_valid_q || m_axis_tready,
               "result overwrote one still waiting")

endmodule

`default_nettype wire
